@@ design/rstg_pkg.sv @@
// ----------------------------------------------------------------------------
// rstg_pkg: shared definitions for the ramped sine tone generator
// Field widths, register indexes, reset values and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rstg_pkg;

	// Field widths fixed by the register map and the sample format.
	localparam int COEF_W     = 32;
	localparam int VAL_W      = 32;
	localparam int AMP_W      = 15;
	localparam int TONE_W     = 24;
	localparam int RAMP_W     = 23;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Gain is amplitude scaled by 2^16; it never reaches 2^31.
	localparam int GAIN_SHIFT = 16;
	localparam int GAIN_W     = 32;

	// Ramp divider: quotient bits retired per cycle and the resulting cycle count.
	localparam int DIV_STEP_BITS = 4;
	localparam int DIV_CYCLES    = GAIN_W / DIV_STEP_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

	// Parameter defaults.
	localparam int INDEX_BITS_DEFAULT = 24;
	localparam int FRAC_BITS_DEFAULT  = 30;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_OSC_COEFFICIENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_OLDER      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_NEWER      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_LENGTH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH     = 3'd5;

	// Register reset values.
	localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd32767;
	localparam logic [TONE_W-1:0] TONE_RESET = 24'd48000;

	// Saturation limits.
	localparam logic signed [VAL_W-1:0]    VAL_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0]    VAL_MIN    = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // capture the input word, reload seeds on restart
		logic prep;      // evaluate index tests, start the resonator multiply
		logic reso;      // finish the resonator, set up the gain
		logic div_step;  // retire DIV_STEP_BITS quotient bits
		logic scale;     // multiply the sine value by the gain
		logic load_out;  // round and load the result register
	} rstg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic active;    // this word produces a tone sample
		logic use_div;   // the gain comes from the ramp divider
	} rstg_status_t;

endpackage

@@ design/ramped_sine_tone_generator_unit.sv @@
// ----------------------------------------------------------------------------
// ramped_sine_tone_generator_unit: ramped sine tone generator, top level
// Second-order resonator sine source with a linear amplitude ramp at the
// start and end of a tone of programmable length, giving one stereo sample
// per input word.
// ----------------------------------------------------------------------------
// Every input word yields exactly one output word. A word with advance set
// and the tone not yet finished produces the next tone sample; otherwise the
// output sample is zero and tone_done tells whether the tone has ended. A
// restart reloads the two seed values and rewinds to sample zero before the
// sample of the same word is made. Words are handled one at a time: a word
// without a ramp steps through accept, index tests with the resonator
// multiply, resonator update, gain multiply and output load, and a word that
// falls on the rising or falling ramp adds the ramp gain divider, which
// retires four quotient bits a cycle, after the resonator update. A word
// that makes no sample skips the gain multiply. A result that is not taken
// holds the next word back in the output load step until the output
// register frees up.
// The result sits in an output register, so a new word can be accepted
// while the previous result still waits to be taken.
// The configuration port is always ready; registers should only be written
// while no word is in flight. Writes to indexes beyond the register list are
// ignored.
module ramped_sine_tone_generator_unit
	import rstg_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
	parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration write channel.
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	// Input word channel.
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       restart,
	input  logic                       advance,
	// Output word channel.
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] left_sample,
	output logic signed [SAMPLE_W-1:0] right_sample,
	output logic                       last_sample,
	output logic                       tone_done
);

	rstg_cmd_t    cmd;
	rstg_status_t status;

	// Registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	rstg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rstg_dp #(
		.INDEX_BITS (INDEX_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.restart      (restart),
		.advance      (advance),
		.cmd          (cmd),
		.status       (status),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_sample  (last_sample),
		.tone_done    (tone_done)
	);

endmodule

@@ design/rstg_ctrl.sv @@
// ----------------------------------------------------------------------------
// rstg_ctrl: sequencing controller
// Walks each accepted word through prepare, resonator, optional ramp divide,
// optional scale and output load, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rstg_ctrl
	import rstg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  rstg_status_t status,
	output rstg_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_RESO,
		S_DIV,
		S_SCALE,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.accept   = in_valid && (state_q == S_IDLE);
		cmd.prep     = (state_q == S_PREP);
		cmd.reso     = (state_q == S_RESO);
		cmd.div_step = (state_q == S_DIV);
		cmd.scale    = (state_q == S_SCALE);
		cmd.load_out = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_RESO;
				end
				S_RESO: begin
					div_cnt_q <= '0;
					priority if (!status.active) begin
						state_q <= S_OUT;
					end else if (status.use_div) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_SCALE;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/rstg_dp.sv @@
// ----------------------------------------------------------------------------
// rstg_dp: datapath
// Configuration registers, resonator state, sample index, ramp gain divider,
// output scaling and the result register.
// ----------------------------------------------------------------------------
module rstg_dp
	import rstg_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
	parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       restart,
	input  logic                       advance,
	input  rstg_cmd_t                  cmd,
	output rstg_status_t               status,
	output logic signed [SAMPLE_W-1:0] left_sample,
	output logic signed [SAMPLE_W-1:0] right_sample,
	output logic                       last_sample,
	output logic                       tone_done
);

	localparam int CMP_W       = ((INDEX_BITS > TONE_W) ? INDEX_BITS : TONE_W) + 1;
	localparam int AN_W        = AMP_W + RAMP_W;
	localparam int DVD_W       = AN_W + GAIN_SHIFT;
	localparam int PROD_W      = 2 * VAL_W;
	localparam int SCALE_SHIFT = FRAC_BITS + GAIN_SHIFT;
	localparam logic [PROD_W-1:0] SCALE_BIAS = (PROD_W'(1) << SCALE_SHIFT) - PROD_W'(1);

	// Configuration registers.
	logic signed [COEF_W-1:0] coef_q;
	logic signed [VAL_W-1:0]  seed_old_q;
	logic signed [VAL_W-1:0]  seed_new_q;
	logic [AMP_W-1:0]         amp_q;
	logic [TONE_W-1:0]        tone_q;
	logic [RAMP_W-1:0]        ramp_q;

	// Tone state.
	logic signed [VAL_W-1:0]  older_q;
	logic signed [VAL_W-1:0]  newer_q;
	logic [INDEX_BITS-1:0]    idx_q;
	logic                     adv_q;

	// Per-word working registers.
	logic                     done_q;
	logic                     active_q;
	logic                     last_q;
	logic                     use_div_q;
	logic [RAMP_W-1:0]        n_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [VAL_W-1:0]  y_q;
	logic [RAMP_W-1:0]        div_rem_q;
	logic [GAIN_W-1:0]        div_work_q;
	logic signed [PROD_W-1:0] mul_q;

	// Result register.
	logic signed [SAMPLE_W-1:0] res_sample_q;
	logic                       res_last_q;
	logic                       res_done_q;

	// Index tests.
	logic [CMP_W-1:0] idx_w, tone_w, ramp_w, fall_n_w;
	logic             done_c, rise_c, fall_c, ramp_on;

	assign idx_w    = CMP_W'(idx_q);
	assign tone_w   = CMP_W'(tone_q);
	assign ramp_w   = CMP_W'(ramp_q);
	assign fall_n_w = tone_w - idx_w;
	assign ramp_on  = (ramp_q != '0);
	assign done_c   = (idx_w >= tone_w);
	assign rise_c   = ramp_on && (idx_w < ramp_w);
	assign fall_c   = ramp_on && ((idx_w + ramp_w) > tone_w);

	// Resonator: floor by 2^FRAC_BITS, subtract, saturate to 32 bits.
	logic signed [PROD_W-1:0] q_c, diff_c;
	logic signed [VAL_W-1:0]  y_c;

	assign q_c    = prod_q >>> FRAC_BITS;
	assign diff_c = q_c - PROD_W'(older_q);

	always_comb begin
		if (diff_c[PROD_W-1:VAL_W-1] == '0 || diff_c[PROD_W-1:VAL_W-1] == '1) begin
			y_c = diff_c[VAL_W-1:0];
		end else if (diff_c[PROD_W-1]) begin
			y_c = VAL_MIN;
		end else begin
			y_c = VAL_MAX;
		end
	end

	// Gain setup: amplitude times ramp position, scaled by 2^GAIN_SHIFT.
	// The quotient stays below 2^GAIN_W, so the part above it starts as remainder.
	logic [AN_W-1:0]  amp_n_c;
	logic [DVD_W-1:0] dvd_c;

	assign amp_n_c = AN_W'(amp_q) * AN_W'(n_q);
	assign dvd_c   = {amp_n_c, GAIN_SHIFT'(0)};

	// Restoring divider, DIV_STEP_BITS quotient bits a cycle.
	logic [RAMP_W-1:0] rem_nx;
	logic [GAIN_W-1:0] work_nx;
	logic [RAMP_W:0]   trial;

	always_comb begin
		rem_nx  = div_rem_q;
		work_nx = div_work_q;
		trial   = '0;
		for (int k = 0; k < DIV_STEP_BITS; k++) begin
			trial   = {rem_nx, work_nx[GAIN_W-1]};
			work_nx = {work_nx[GAIN_W-2:0], 1'b0};
			if (trial >= {1'b0, ramp_q}) begin
				trial      = trial - {1'b0, ramp_q};
				work_nx[0] = 1'b1;
			end
			rem_nx = trial[RAMP_W-1:0];
		end
	end

	// Output rounding: truncate toward zero, then saturate to 16 bits.
	logic signed [PROD_W-1:0]   biased_c, shifted_c;
	logic signed [SAMPLE_W-1:0] sample_c;

	assign biased_c  = mul_q + (mul_q[PROD_W-1] ? $signed(SCALE_BIAS) : PROD_W'(0));
	assign shifted_c = biased_c >>> SCALE_SHIFT;

	always_comb begin
		if (shifted_c[PROD_W-1:SAMPLE_W-1] == '0 || shifted_c[PROD_W-1:SAMPLE_W-1] == '1) begin
			sample_c = shifted_c[SAMPLE_W-1:0];
		end else if (shifted_c[PROD_W-1]) begin
			sample_c = SAMPLE_MIN;
		end else begin
			sample_c = SAMPLE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q     <= '0;
			seed_old_q <= '0;
			seed_new_q <= '0;
			amp_q      <= AMP_RESET;
			tone_q     <= TONE_RESET;
			ramp_q     <= '0;
			older_q    <= '0;
			newer_q    <= '0;
			idx_q      <= '0;
			adv_q      <= 1'b0;
			done_q     <= 1'b0;
			active_q   <= 1'b0;
			use_div_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_OSC_COEFFICIENT: coef_q     <= cfg_data;
					REG_SEED_OLDER:      seed_old_q <= cfg_data;
					REG_SEED_NEWER:      seed_new_q <= cfg_data;
					REG_AMPLITUDE:       amp_q      <= cfg_data[AMP_W-1:0];
					REG_TONE_LENGTH:     tone_q     <= cfg_data[TONE_W-1:0];
					REG_RAMP_LENGTH:     ramp_q     <= cfg_data[RAMP_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				adv_q <= advance;
				if (restart) begin
					older_q <= seed_old_q;
					newer_q <= seed_new_q;
					idx_q   <= '0;
				end
			end
			if (cmd.prep) begin
				done_q    <= done_c;
				active_q  <= adv_q && !done_c;
				use_div_q <= rise_c || fall_c;
			end
			if (cmd.reso && active_q) begin
				older_q <= newer_q;
				newer_q <= y_c;
				idx_q   <= idx_q + INDEX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			prod_q <= PROD_W'(coef_q) * PROD_W'(newer_q);
			last_q <= ((idx_w + CMP_W'(1)) == tone_w);
			// The rise wins where both ramps overlap.
			n_q    <= rise_c ? idx_w[RAMP_W-1:0] : fall_n_w[RAMP_W-1:0];
		end
		if (cmd.reso) begin
			y_q <= y_c;
			if (use_div_q) begin
				div_rem_q  <= RAMP_W'(dvd_c[DVD_W-1:GAIN_W]);
				div_work_q <= dvd_c[GAIN_W-1:0];
			end else begin
				div_work_q <= {1'b0, amp_q, GAIN_SHIFT'(0)};
			end
		end
		if (cmd.div_step) begin
			div_rem_q  <= rem_nx;
			div_work_q <= work_nx;
		end
		if (cmd.scale) begin
			mul_q <= PROD_W'(y_q) * PROD_W'($signed({1'b0, div_work_q[GAIN_W-2:0]}));
		end
		if (cmd.load_out) begin
			res_sample_q <= active_q ? sample_c : '0;
			res_last_q   <= active_q && last_q;
			res_done_q   <= done_q;
		end
	end

	assign status.active  = active_q;
	assign status.use_div = use_div_q;

	assign left_sample  = res_sample_q;
	assign right_sample = res_sample_q;
	assign last_sample  = res_last_q;
	assign tone_done    = res_done_q;

endmodule
